>>> rtl/core/ils_pkg.sv
// Shared types and constants for the indexed list store.
`default_nettype none

package ils_pkg;

   // Field widths of the request and response words
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 7;
   localparam int LENGTH_W = 7;

   // Default number of list cells
   localparam int DEFAULT_CAPACITY = 64;

   // Action codes carried in req_action
   localparam logic [2:0] ACT_READ   = 3'd0;
   localparam logic [2:0] ACT_FRONT  = 3'd1;
   localparam logic [2:0] ACT_BACK   = 3'd2;
   localparam logic [2:0] ACT_AT     = 3'd3;
   localparam logic [2:0] ACT_DELETE = 3'd4;

   // Read data returned for an index past the end of the list
   localparam logic [VALUE_W-1:0] NOT_FOUND_VALUE = '1;

   // What every cell of the row does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_DELETE = 2'd2
   } cell_op_type;

   // Broadcast from the controller to every cell
   typedef struct packed {
      cell_op_type        op;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/core/ils_cell.sv
// One list cell: holds one entry, shifts on insert or delete, forwards read data.
`default_nettype none

module ils_cell #(
   parameter int CW  = 7,
   parameter int POS = 0
) (
   input  wire                          clock,
   input  ils_pkg::cell_ctrl_type       ctrl,
   input  wire  [CW-1:0]                pos,
   input  wire  [CW-1:0]                rd_pos,
   input  wire  [ils_pkg::VALUE_W-1:0]  left_data,
   input  wire  [ils_pkg::VALUE_W-1:0]  right_data,
   input  wire  [ils_pkg::VALUE_W-1:0]  right_rd,
   output logic [ils_pkg::VALUE_W-1:0]  data_q,
   output logic [ils_pkg::VALUE_W-1:0]  rd_q
);
   import ils_pkg::*;

   localparam logic [CW-1:0] MY_POS = CW'(POS);

   logic [VALUE_W-1:0] data_ff, data_in;
   logic [VALUE_W-1:0] rd_ff, rd_in;

   // Entry update: cells behind the touched place take a neighbour's word
   always_comb begin
      data_in = data_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (MY_POS == pos) begin
               data_in = ctrl.value;
            end else if (MY_POS > pos) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (MY_POS >= pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   // Read path: the selected cell launches its word, the rest pass it on
   always_comb begin
      rd_in = (MY_POS == rd_pos) ? data_ff : right_rd;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rd_ff   <= rd_in;
   end

   assign data_q = data_ff;
   assign rd_q   = rd_ff;

endmodule

`default_nettype wire

>>> rtl/core/indexed_list_store.sv
// Top level of the indexed list store: controller and row of list cells.
//
//  channel   ports                                    handshake
//  request   req_action, req_index, req_value         start high and busy low
//  response  rsp_read_value, rsp_found, rsp_accepted, rsp_strobe high, one cycle
//            rsp_length
//
// Insert, delete and out-of-range read: the word is taken and its response strobes
// in the next cycle; busy stays low, so a word can enter every cycle.
// A read at index k walks the word down the cell row to cell 0 while busy is high;
// the response strobes in the first cycle with busy low.
// Synchronous reset empties the list; stored entries are not cleared.
// The receiver cannot stall: each response is shown for exactly one cycle.
`default_nettype none

module indexed_list_store #(
   parameter int CAPACITY = ils_pkg::DEFAULT_CAPACITY
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire  [2:0]                    req_action,
   input  wire  [ils_pkg::INDEX_W-1:0]   req_index,
   input  wire  [ils_pkg::VALUE_W-1:0]   req_value,
   output logic                          rsp_strobe,
   output logic [ils_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic                          rsp_found,
   output logic                          rsp_accepted,
   output logic [ils_pkg::LENGTH_W-1:0]  rsp_length
);
   import ils_pkg::*;

   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CW > INDEX_W) ? CW : INDEX_W;
   localparam int WALK_W = INDEX_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [INDEX_W-1:0]   idx_ff;
   logic [WALK_W-1:0]    walk_ff;

   logic                 rsp_strobe_ff;
   logic [VALUE_W-1:0]   rsp_value_ff;
   logic                 rsp_found_ff;
   logic                 rsp_accepted_ff;
   logic [LENGTH_W-1:0]  rsp_length_ff;

   cell_ctrl_type        ctrl;
   logic [CMP_W-1:0]     idx_ext, count_ext, ins_pos;
   logic [CW-1:0]        cell_pos;
   logic                 accept, go_read, is_insert, change_ok, walk_done;
   logic [VALUE_W-1:0]   imm_value;
   logic                 imm_found;

   logic [VALUE_W-1:0]   data_row [CAPACITY];
   logic [VALUE_W-1:0]   rd_row   [CAPACITY];

   assign accept    = start && (state_ff == ST_IDLE);
   assign idx_ext   = CMP_W'(req_index);
   assign count_ext = CMP_W'(count_ff);
   assign walk_done = (walk_ff == ({1'b0, idx_ff} + WALK_W'(1)));

   // Decode the request word into a cell command and an immediate response
   always_comb begin
      ins_pos   = '0;
      is_insert = 1'b0;
      change_ok = 1'b0;
      go_read   = 1'b0;
      imm_value = '0;
      imm_found = 1'b0;
      case (req_action)
         ACT_READ: begin
            if (idx_ext < count_ext) begin
               go_read = 1'b1;
            end else begin
               imm_value = NOT_FOUND_VALUE;
            end
         end
         ACT_FRONT: begin
            is_insert = 1'b1;
            ins_pos   = '0;
         end
         ACT_BACK: begin
            is_insert = 1'b1;
            ins_pos   = count_ext;
         end
         ACT_AT: begin
            is_insert = 1'b1;
            ins_pos   = idx_ext;
         end
         ACT_DELETE: begin
            ins_pos   = idx_ext;
            change_ok = (idx_ext < count_ext);
         end
         default: begin
            ins_pos = '0;
         end
      endcase
      if (is_insert) begin
         change_ok = (count_ext < CMP_W'(CAPACITY)) && (ins_pos <= count_ext);
      end
   end

   // Cell command and list length
   always_comb begin
      ctrl.value = req_value;
      ctrl.op    = CELL_HOLD;
      count_in   = count_ff;
      if (accept && change_ok) begin
         if (is_insert) begin
            ctrl.op  = CELL_INSERT;
            count_in = count_ff + CW'(1);
         end else begin
            ctrl.op  = CELL_DELETE;
            count_in = count_ff - CW'(1);
         end
      end
   end

   assign cell_pos = CW'(ins_pos);

   // Sequencer for the read walk
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && go_read) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (walk_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff  <= req_index;
         walk_ff <= '0;
      end else begin
         walk_ff <= walk_ff + WALK_W'(1);
      end
   end

   // Response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= (accept && !go_read) || ((state_ff == ST_READ) && walk_done);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_value_ff    <= imm_value;
         rsp_found_ff    <= imm_found;
         rsp_accepted_ff <= change_ok;
         rsp_length_ff   <= LENGTH_W'(CMP_W'(count_in));
      end else if ((state_ff == ST_READ) && walk_done) begin
         rsp_value_ff    <= rd_row[0];
         rsp_found_ff    <= 1'b1;
         rsp_accepted_ff <= 1'b0;
         rsp_length_ff   <= LENGTH_W'(count_ext);
      end
   end

   // Row of list cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_w, right_w, right_rd_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = data_row[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_w    = '0;
         assign right_rd_w = '0;
      end else begin : g_mid_r
         assign right_w    = data_row[i+1];
         assign right_rd_w = rd_row[i+1];
      end
      ils_cell #(
         .CW  (CW),
         .POS (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (cell_pos),
         .rd_pos     (CW'(CMP_W'(idx_ff))),
         .left_data  (left_w),
         .right_data (right_w),
         .right_rd   (right_rd_w),
         .data_q     (data_row[i]),
         .rd_q       (rd_row[i])
      );
   end

   assign busy           = (state_ff == ST_READ);
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_accepted   = rsp_accepted_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

`default_nettype wire

>>> rtl/core/ils_checker.sv
// Port-level checks for the indexed list store, bound to the top level.
`default_nettype none

module ils_checker (
   input wire        clock,
   input wire        reset,
   input wire        start,
   input wire        busy,
   input wire        rsp_strobe,
   input wire        rsp_found,
   input wire        rsp_accepted
);
   import ils_pkg::*;

   // Every accepted word either answers next cycle or starts a read walk
   a_accept_answers: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe || busy)
      else $error("accepted word neither answered nor started a walk");

   // A response only follows an accepted word or the end of a walk
   a_strobe_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy) || $fell(busy))
      else $error("response word without a cause");

   // No response is shown while a walk is under way
   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("response during read walk");

   // A read hit never reports a list change
   a_found_not_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found |-> !rsp_accepted)
      else $error("read hit flagged as list change");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_found    (rsp_found),
   .rsp_accepted (rsp_accepted)
);

`default_nettype wire
